### hw/rtl/uherc_pkg.sv
package uherc_pkg;

    // Event TRB type codes handled by the decoder
    localparam logic [5:0] TRB_TRANSFER       = 6'd32;
    localparam logic [5:0] TRB_CMD_COMPLETION = 6'd33;
    localparam logic [5:0] TRB_PORT_CHANGE    = 6'd34;
    localparam logic [5:0] TRB_DOORBELL       = 6'd36;
    localparam logic [5:0] TRB_DEV_NOTIFY     = 6'd38;

    // TRB slots are sixteen bytes apart
    localparam int TRB_BYTE_SHIFT = 4;

    // Decoded fields whose widths do not depend on ring sizes
    typedef struct packed {
        logic        consumed;
        logic [5:0]  trb_type;
        logic [7:0]  completion_code;
        logic [7:0]  slot_id;
        logic [7:0]  vf_id;
        logic [4:0]  endpoint_id;
        logic [63:0] pointer_or_data;
        logic [23:0] length_or_parameter;
        logic        event_data_flag;
        logic [7:0]  aux_code;
    } t_event_fields;

endpackage

### hw/rtl/usb_host_event_ring_consumer_top.sv
// Channel   Direction  Handshake                   Payload
// --------  ---------  --------------------------  ------------------------------------
// in        to block   i_in_valid / o_in_ready     i_word0 .. i_word3 (one event TRB)
// out       from block o_out_valid / i_out_ready   o_consumed .. o_next_dequeue
// cfg       to block   i_cfg_we (no wait)          i_cfg_wdata: command ring base
//
// One TRB per cycle sustained while the output keeps accepting results.
// The TRB sits in an input register, is decoded against the dequeue state and lands
// in the result register; the dequeue index and cycle bit update on that same move.
// A stalled result holds; the input register still takes one more TRB behind it.
// Synchronous active-low reset: index 0, cycle bit 1, base 0, both stages empty.
module usb_host_event_ring_consumer_top #(
    parameter int  EVENT_RING_SIZE   = 128,
    parameter int  COMMAND_RING_SIZE = 128,
    localparam int DEQ_W             = $clog2(EVENT_RING_SIZE),
    localparam int CIDX_W            = $clog2(COMMAND_RING_SIZE) + 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [63:0]       i_cfg_wdata,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [31:0]       i_word0,
    input  logic [31:0]       i_word1,
    input  logic [31:0]       i_word2,
    input  logic [31:0]       i_word3,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic              o_consumed,
    output logic [5:0]        o_trb_type,
    output logic [7:0]        o_completion_code,
    output logic [7:0]        o_slot_id,
    output logic [7:0]        o_vf_id,
    output logic [4:0]        o_endpoint_id,
    output logic [63:0]       o_pointer_or_data,
    output logic [23:0]       o_length_or_parameter,
    output logic              o_event_data_flag,
    output logic [7:0]        o_aux_code,
    output logic [CIDX_W-1:0] o_command_index,
    output logic [DEQ_W-1:0]  o_next_dequeue
);
    import uherc_pkg::*;

    logic              r_in_valid;
    logic [31:0]       r_word0;
    logic [31:0]       r_word1;
    logic [31:0]       r_word2;
    logic [31:0]       r_word3;
    logic [63:0]       r_cmd_base;
    logic              r_out_valid;
    t_event_fields     r_fields;
    logic [CIDX_W-1:0] r_cmd_idx;
    logic [DEQ_W-1:0]  r_next_deq;

    logic              advance;
    logic              match;
    logic [DEQ_W-1:0]  next_index;
    t_event_fields     n_fields;
    logic [CIDX_W-1:0] n_cmd_idx;

    // Stage handshake: decode moves when the result register is free or draining
    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;

    // Command ring base register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmd_base <= '0;
        end else if (i_cfg_we) begin
            r_cmd_base <= i_cfg_wdata;
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_word0 <= i_word0;
            r_word1 <= i_word1;
            r_word2 <= i_word2;
            r_word3 <= i_word3;
        end
    end

    uherc_ring_ptr #(
        .EVENT_RING_SIZE (EVENT_RING_SIZE),
        .DEQ_W           (DEQ_W)
    ) u_ring_ptr (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_take       (advance),
        .i_trb_cycle  (r_word3[0]),
        .o_match      (match),
        .o_next_index (next_index)
    );

    uherc_decode #(
        .COMMAND_RING_SIZE (COMMAND_RING_SIZE),
        .CIDX_W            (CIDX_W)
    ) u_decode (
        .i_word0         (r_word0),
        .i_word1         (r_word1),
        .i_word2         (r_word2),
        .i_word3         (r_word3),
        .i_cmd_base      (r_cmd_base),
        .i_match         (match),
        .o_fields        (n_fields),
        .o_command_index (n_cmd_idx)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_fields   <= n_fields;
            r_cmd_idx  <= n_cmd_idx;
            r_next_deq <= next_index;
        end
    end

    assign o_out_valid           = r_out_valid;
    assign o_consumed            = r_fields.consumed;
    assign o_trb_type            = r_fields.trb_type;
    assign o_completion_code     = r_fields.completion_code;
    assign o_slot_id             = r_fields.slot_id;
    assign o_vf_id               = r_fields.vf_id;
    assign o_endpoint_id         = r_fields.endpoint_id;
    assign o_pointer_or_data     = r_fields.pointer_or_data;
    assign o_length_or_parameter = r_fields.length_or_parameter;
    assign o_event_data_flag     = r_fields.event_data_flag;
    assign o_aux_code            = r_fields.aux_code;
    assign o_command_index       = r_cmd_idx;
    assign o_next_dequeue        = r_next_deq;

`ifndef SYNTHESIS
    a_empty_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_fields.consumed) |->
            ((r_fields.pointer_or_data == '0) && (r_fields.aux_code == '0) &&
             (r_cmd_idx == CIDX_W'(COMMAND_RING_SIZE))))
        else $error("empty-ring result carries decoded fields");

    a_cmd_index_type: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_cmd_idx != CIDX_W'(COMMAND_RING_SIZE))) |->
            (r_fields.consumed && (r_fields.trb_type == TRB_CMD_COMPLETION)))
        else $error("command index set on a non-completion event");

    a_no_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !advance) |=> r_in_valid)
        else $error("held TRB lost from input register");
`endif

endmodule

### hw/rtl/uherc_ring_ptr.sv
module uherc_ring_ptr #(
    parameter int EVENT_RING_SIZE = 128,
    parameter int DEQ_W           = $clog2(EVENT_RING_SIZE)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_take,
    input  logic             i_trb_cycle,
    output logic             o_match,
    output logic [DEQ_W-1:0] o_next_index
);

    logic [DEQ_W-1:0] r_index;
    logic             r_cycle;
    logic [DEQ_W-1:0] n_index;
    logic             n_cycle;
    logic [DEQ_W:0]   idx_inc;
    logic             wrap;

    // Ownership check: TRB belongs to software only when cycle bits agree
    assign o_match = (i_trb_cycle == r_cycle);
    assign idx_inc = {1'b0, r_index} + {{DEQ_W{1'b0}}, 1'b1};
    assign wrap    = (idx_inc >= (DEQ_W+1)'(EVENT_RING_SIZE));

    // Index after this TRB; unchanged when the ring is empty
    always_comb begin
        n_index = r_index;
        n_cycle = r_cycle;
        if (o_match) begin
            if (wrap) begin
                n_index = '0;
                n_cycle = ~r_cycle;
            end else begin
                n_index = idx_inc[DEQ_W-1:0];
            end
        end
    end

    assign o_next_index = n_index;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_index <= '0;
            r_cycle <= 1'b1;
        end else if (i_take) begin
            r_index <= n_index;
            r_cycle <= n_cycle;
        end
    end

`ifndef SYNTHESIS
    a_empty_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_take && !o_match) |=> ($stable(r_index) && $stable(r_cycle)))
        else $error("dequeue state moved on an empty ring");

    a_step_no_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_take && o_match && !wrap) |=>
            ((r_index == $past(idx_inc[DEQ_W-1:0])) && $stable(r_cycle)))
        else $error("dequeue index did not advance by one");

    a_wrap_toggles: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_take && o_match && wrap) |=> ((r_index == '0) && (r_cycle != $past(r_cycle))))
        else $error("ring wrap did not clear index and toggle cycle");

    a_index_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ({1'b0, r_index} < (DEQ_W+1)'(EVENT_RING_SIZE)))
        else $error("dequeue index beyond ring end");
`endif

endmodule

### hw/rtl/uherc_decode.sv
module uherc_decode #(
    parameter int COMMAND_RING_SIZE = 128,
    parameter int CIDX_W            = $clog2(COMMAND_RING_SIZE) + 1
) (
    input  logic [31:0]                i_word0,
    input  logic [31:0]                i_word1,
    input  logic [31:0]                i_word2,
    input  logic [31:0]                i_word3,
    input  logic [63:0]                i_cmd_base,
    input  logic                       i_match,
    output uherc_pkg::t_event_fields   o_fields,
    output logic [CIDX_W-1:0]          o_command_index
);
    import uherc_pkg::*;

    localparam int SLOT_W = 64 - TRB_BYTE_SHIFT;

    logic [63:0]       ptr;
    logic [63:0]       offset;
    logic [SLOT_W-1:0] slot;
    logic              slot_in_range;
    logic [5:0]        trb_type;

    assign ptr      = {i_word1, i_word0};
    assign trb_type = i_word3[15:10];

    // Command ring slot: byte offset from base, sixteen bytes per TRB
    assign offset        = ptr - i_cmd_base;
    assign slot          = offset[63:TRB_BYTE_SHIFT];
    assign slot_in_range = (slot < SLOT_W'(COMMAND_RING_SIZE));

    always_comb begin
        o_fields        = '0;
        o_command_index = CIDX_W'(COMMAND_RING_SIZE);
        if (i_match) begin
            // common fields
            o_fields.consumed        = 1'b1;
            o_fields.trb_type        = trb_type;
            o_fields.completion_code = i_word2[31:24];
            o_fields.slot_id         = i_word3[31:24];
            o_fields.vf_id           = i_word3[23:16];

            // type-specific fields
            case (trb_type)
                TRB_TRANSFER: begin
                    o_fields.endpoint_id         = i_word3[20:16];
                    o_fields.pointer_or_data     = ptr;
                    o_fields.length_or_parameter = i_word2[23:0];
                    o_fields.event_data_flag     = i_word3[2];
                end
                TRB_CMD_COMPLETION: begin
                    o_fields.pointer_or_data     = ptr;
                    o_fields.length_or_parameter = i_word2[23:0];
                    if (slot_in_range) begin
                        o_command_index = slot[CIDX_W-1:0];
                    end
                end
                TRB_PORT_CHANGE: begin
                    o_fields.aux_code = i_word0[31:24];
                end
                TRB_DOORBELL: begin
                    o_fields.aux_code = {3'b000, i_word0[4:0]};
                end
                TRB_DEV_NOTIFY: begin
                    o_fields.pointer_or_data = {8'h00, ptr[63:8]};
                    o_fields.aux_code        = {4'h0, i_word0[7:4]};
                end
                default: begin
                end
            endcase
        end
    end

endmodule

### tb/usb_host_event_ring_consumer_top_tb.sv
`timescale 1ns / 100ps

module usb_host_event_ring_consumer_top_tb;

    import uherc_pkg::*;

    localparam int         EVENT_RING_SIZE   = 128;
    localparam int         COMMAND_RING_SIZE = 128;
    localparam logic [7:0] CMD_SLOT_NONE     = 8'd128;
    localparam logic [63:0] DIRECTED_BASE    = 64'h0000_0001_0000_1000;

    // One event TRB as offered on the input channel
    typedef struct {
        logic [31:0] w0;
        logic [31:0] w1;
        logic [31:0] w2;
        logic [31:0] w3;
        int          gap;
        bit          drain;
    } t_trb_item;

    // Decoded event plus the ring-size dependent fields
    typedef struct packed {
        t_event_fields f;
        logic [7:0]    cmd_index;
        logic [6:0]    next_deq;
    } t_event_result;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_cfg_we      = 1'b0;
    logic [63:0] i_cfg_wdata   = '0;
    logic        i_in_valid    = 1'b0;
    logic        o_in_ready;
    logic [31:0] i_word0       = '0;
    logic [31:0] i_word1       = '0;
    logic [31:0] i_word2       = '0;
    logic [31:0] i_word3       = '0;
    logic        o_out_valid;
    logic        i_out_ready   = 1'b0;
    logic        o_consumed;
    logic [5:0]  o_trb_type;
    logic [7:0]  o_completion_code;
    logic [7:0]  o_slot_id;
    logic [7:0]  o_vf_id;
    logic [4:0]  o_endpoint_id;
    logic [63:0] o_pointer_or_data;
    logic [23:0] o_length_or_parameter;
    logic        o_event_data_flag;
    logic [7:0]  o_aux_code;
    logic [7:0]  o_command_index;
    logic [6:0]  o_next_dequeue;

    // TRBs waiting to be offered, and decoded events waiting on the output
    t_trb_item     trb_q[$];
    t_event_result pending_events[$];

    // Predictor copy of the dequeue state and the command ring base
    logic [6:0]  ring_slot  = '0;
    logic        ring_cycle = 1'b1;
    logic [63:0] ring_base  = '0;

    // Producer-side view of the ring, used to write the right cycle bit
    logic [6:0]  lap_slot  = '0;
    logic        lap_cycle = 1'b1;
    bit          tx_burst  = 1'b0;
    bit          rx_burst  = 1'b0;

    t_trb_item tx_cur;
    int        tx_wait = 0;
    int        rx_stall = 0;
    int        rx_hold = 0;
    int        results_seen = 0;
    int        mismatches = 0;
    int        n_taken = 0;
    int        n_empty = 0;
    int        n_wraps = 0;
    int        n_cmd_slots = 0;
    int        kind_hits[6] = '{default: 0};

    usb_host_event_ring_consumer_top #(
        .EVENT_RING_SIZE  (EVENT_RING_SIZE),
        .COMMAND_RING_SIZE(COMMAND_RING_SIZE)
    ) DUT (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cfg_we             (i_cfg_we),
        .i_cfg_wdata          (i_cfg_wdata),
        .i_in_valid           (i_in_valid),
        .o_in_ready           (o_in_ready),
        .i_word0              (i_word0),
        .i_word1              (i_word1),
        .i_word2              (i_word2),
        .i_word3              (i_word3),
        .o_out_valid          (o_out_valid),
        .i_out_ready          (i_out_ready),
        .o_consumed           (o_consumed),
        .o_trb_type           (o_trb_type),
        .o_completion_code    (o_completion_code),
        .o_slot_id            (o_slot_id),
        .o_vf_id              (o_vf_id),
        .o_endpoint_id        (o_endpoint_id),
        .o_pointer_or_data    (o_pointer_or_data),
        .o_length_or_parameter(o_length_or_parameter),
        .o_event_data_flag    (o_event_data_flag),
        .o_aux_code           (o_aux_code),
        .o_command_index      (o_command_index),
        .o_next_dequeue       (o_next_dequeue)
    );

    always #5 i_clk = ~i_clk;

    task automatic report_mismatch(input string msg);
        mismatches++;
        if (mismatches <= 40) begin
            $display("[%0t] MISMATCH: %s", $time, msg);
        end
    endtask

    task automatic check_field(input string name, input logic [63:0] got,
                               input logic [63:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("result %0d %s: got %0h, expected %0h",
                                      results_seen, name, got, want));
        end
    endtask

    // Take or skip one TRB against the dequeue state, then decode it
    function automatic t_event_result decode_event_trb(input t_trb_item t);
        t_event_result r;
        logic [63:0]   ptr;
        logic [63:0]   slot_off;
        r = '0;
        r.cmd_index = CMD_SLOT_NONE;
        ptr = {t.w1, t.w0};
        // cycle bit mismatch: ring empty, state untouched
        if (t.w3[0] != ring_cycle) begin
            r.next_deq = ring_slot;
            n_empty++;
            return r;
        end
        if (ring_slot == 7'(EVENT_RING_SIZE - 1)) begin
            ring_slot  = '0;
            ring_cycle = ~ring_cycle;
            n_wraps++;
        end else begin
            ring_slot = ring_slot + 7'd1;
        end
        n_taken++;
        r.f.consumed        = 1'b1;
        r.f.trb_type        = t.w3[15:10];
        r.f.completion_code = t.w2[31:24];
        r.f.slot_id         = t.w3[31:24];
        r.f.vf_id           = t.w3[23:16];
        case (r.f.trb_type)
            TRB_TRANSFER: begin
                r.f.endpoint_id         = t.w3[20:16];
                r.f.pointer_or_data     = ptr;
                r.f.length_or_parameter = t.w2[23:0];
                r.f.event_data_flag     = t.w3[2];
                kind_hits[0]++;
            end
            TRB_CMD_COMPLETION: begin
                r.f.pointer_or_data     = ptr;
                r.f.length_or_parameter = t.w2[23:0];
                // wraps when the pointer sits below the base
                slot_off = (ptr - ring_base) >> TRB_BYTE_SHIFT;
                if (slot_off < COMMAND_RING_SIZE) begin
                    r.cmd_index = slot_off[7:0];
                    n_cmd_slots++;
                end
                kind_hits[1]++;
            end
            TRB_PORT_CHANGE: begin
                r.f.aux_code = t.w0[31:24];
                kind_hits[2]++;
            end
            TRB_DOORBELL: begin
                r.f.aux_code = {3'b000, t.w0[4:0]};
                kind_hits[3]++;
            end
            TRB_DEV_NOTIFY: begin
                r.f.pointer_or_data = ptr >> 8;
                r.f.aux_code        = {4'b0000, t.w0[7:4]};
                kind_hits[4]++;
            end
            default: begin
                kind_hits[5]++;
            end
        endcase
        r.next_deq = ring_slot;
        return r;
    endfunction

    // Queue one TRB; take selects a matching or a stale cycle bit
    task automatic queue_trb(input logic [31:0] w0, input logic [31:0] w1,
                             input logic [31:0] w2, input logic [31:0] w3raw,
                             input logic [5:0] kind, input bit take, input bit drain);
        t_trb_item t;
        t.w0    = w0;
        t.w1    = w1;
        t.w2    = w2;
        t.w3    = {w3raw[31:16], kind, w3raw[9:1], take ? lap_cycle : ~lap_cycle};
        t.gap   = tx_burst ? 0 : $urandom_range(0, 14);
        t.drain = drain;
        if (take) begin
            if (lap_slot == 7'(EVENT_RING_SIZE - 1)) begin
                lap_slot  = '0;
                lap_cycle = ~lap_cycle;
            end else begin
                lap_slot = lap_slot + 7'd1;
            end
        end
        trb_q.insert(trb_q.size(), t);
    endtask

    // Mostly well-formed producer traffic, some stale slots and odd types
    task automatic queue_random_trbs(input int count, input int drain_at);
        logic [63:0] p;
        logic [5:0]  kind;
        int          i;
        int          idx;
        int          off;
        for (i = 0; i < count; i++) begin
            if (i % 40 == 0) begin
                tx_burst = ($urandom_range(0, 2) == 0);
            end
            case ($urandom_range(0, 5))
                0: kind = TRB_TRANSFER;
                1: kind = TRB_CMD_COMPLETION;
                2: kind = TRB_PORT_CHANGE;
                3: kind = TRB_DOORBELL;
                4: kind = TRB_DEV_NOTIFY;
                default: kind = 6'($urandom);
            endcase
            p = {$urandom, $urandom};
            // aim most command pointers at or just past the command ring
            if (kind == TRB_CMD_COMPLETION && $urandom_range(0, 3) != 0) begin
                idx = $urandom_range(0, 140);
                off = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : 0;
                p   = ring_base + 64'(idx * 16 + off);
            end
            queue_trb(p[31:0], p[63:32], $urandom, $urandom, kind,
                      $urandom_range(0, 6) != 0, i == drain_at);
        end
    endtask

    // Wait until nothing is queued, offered or in flight, then let the pipe settle
    task automatic wait_idle();
        int n;
        n = 0;
        do begin
            @(negedge i_clk);
            n++;
        end while ((trb_q.size() != 0 || i_in_valid || pending_events.size() != 0)
                   && n < 20000);
        if (pending_events.size() != 0) begin
            report_mismatch($sformatf("%0d decoded events never came out",
                                      pending_events.size()));
        end
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_ring_base(input logic [63:0] base);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= base;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        ring_base = base;
    endtask

    // Input side: offer TRBs, predict each one at its transfer
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            tx_wait = 0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                pending_events.insert(pending_events.size(), decode_event_trb(tx_cur));
            end
            if (!i_in_valid || o_in_ready) begin
                if (trb_q.size() != 0 && tx_wait >= trb_q[0].gap &&
                    !(trb_q[0].drain && pending_events.size() != 0)) begin
                    tx_cur = trb_q.pop_front();
                    i_word0    <= tx_cur.w0;
                    i_word1    <= tx_cur.w1;
                    i_word2    <= tx_cur.w2;
                    i_word3    <= tx_cur.w3;
                    i_in_valid <= 1'b1;
                    tx_wait = 0;
                end else begin
                    i_in_valid <= 1'b0;
                    if (trb_q.size() != 0) begin
                        tx_wait++;
                    end
                end
            end
        end
    end

    // Output side: random stalls, one long hold-off, field-by-field check
    always @(posedge i_clk) begin
        t_event_result want;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            rx_stall = 0;
            rx_hold  = 0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (pending_events.size() == 0) begin
                    report_mismatch($sformatf("result %0d with no event pending",
                                              results_seen));
                end else begin
                    want = pending_events.pop_front();
                    check_field("consumed", o_consumed, want.f.consumed);
                    check_field("trb_type", o_trb_type, want.f.trb_type);
                    check_field("completion_code", o_completion_code,
                                want.f.completion_code);
                    check_field("slot_id", o_slot_id, want.f.slot_id);
                    check_field("vf_id", o_vf_id, want.f.vf_id);
                    check_field("endpoint_id", o_endpoint_id, want.f.endpoint_id);
                    check_field("pointer_or_data", o_pointer_or_data,
                                want.f.pointer_or_data);
                    check_field("length_or_parameter", o_length_or_parameter,
                                want.f.length_or_parameter);
                    check_field("event_data_flag", o_event_data_flag,
                                want.f.event_data_flag);
                    check_field("aux_code", o_aux_code, want.f.aux_code);
                    check_field("command_index", o_command_index, want.cmd_index);
                    check_field("next_dequeue", o_next_dequeue, want.next_deq);
                end
                results_seen++;
                if (results_seen % 40 == 0) begin
                    rx_burst = ($urandom_range(0, 2) == 0);
                end
                rx_stall = rx_burst ? 0 : $urandom_range(0, 14);
                // long back-pressure so the pipe fills and stalls its input
                if (results_seen == 150) begin
                    rx_hold = 100;
                end
            end
            if (rx_hold != 0) begin
                rx_hold--;
                i_out_ready <= 1'b0;
            end else if (rx_stall != 0) begin
                rx_stall--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    // Stimulus and end of run
    initial begin
        logic [63:0] p;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // directed: field extremes, every event kind, empty ring, slot edge cases
        write_ring_base(DIRECTED_BASE);
        queue_trb('1, '1, '1, '1, TRB_TRANSFER, 1'b1, 1'b0);
        queue_trb('0, '0, '0, '0, TRB_TRANSFER, 1'b1, 1'b0);
        p = DIRECTED_BASE;
        queue_trb(p[31:0], p[63:32], '1, '1, TRB_CMD_COMPLETION, 1'b1, 1'b0);
        p = DIRECTED_BASE + 64'd2047;
        queue_trb(p[31:0], p[63:32], $urandom, $urandom, TRB_CMD_COMPLETION, 1'b1, 1'b0);
        p = DIRECTED_BASE + 64'd2048;
        queue_trb(p[31:0], p[63:32], $urandom, $urandom, TRB_CMD_COMPLETION, 1'b1, 1'b0);
        p = DIRECTED_BASE - 64'd16;
        queue_trb(p[31:0], p[63:32], '0, '0, TRB_CMD_COMPLETION, 1'b1, 1'b0);
        p = DIRECTED_BASE + 64'd87;
        queue_trb(p[31:0], p[63:32], $urandom, $urandom, TRB_CMD_COMPLETION, 1'b1, 1'b0);
        queue_trb(32'hA500_0000 | ($urandom & 32'h00FF_FFFF), $urandom, $urandom,
                  $urandom, TRB_PORT_CHANGE, 1'b1, 1'b0);
        queue_trb('1, '1, '1, '1, TRB_PORT_CHANGE, 1'b1, 1'b0);
        queue_trb('1, '1, '1, '1, TRB_DOORBELL, 1'b1, 1'b0);
        queue_trb(32'h0000_0013, '0, '0, '0, TRB_DOORBELL, 1'b1, 1'b0);
        queue_trb('1, '1, '1, '1, TRB_DEV_NOTIFY, 1'b1, 1'b0);
        queue_trb($urandom, $urandom, $urandom, $urandom, TRB_DEV_NOTIFY, 1'b1, 1'b0);
        queue_trb('1, '1, '1, '1, 6'd0, 1'b1, 1'b0);
        queue_trb('1, '1, '1, '1, 6'd63, 1'b1, 1'b0);
        queue_trb($urandom, $urandom, $urandom, $urandom, 6'd35, 1'b1, 1'b0);
        queue_trb($urandom, $urandom, $urandom, $urandom, 6'd37, 1'b1, 1'b0);
        queue_trb($urandom, $urandom, $urandom, $urandom, 6'd39, 1'b1, 1'b0);
        queue_trb('1, '1, '1, '1, TRB_TRANSFER, 1'b0, 1'b0);
        queue_trb('0, '0, '0, '0, TRB_TRANSFER, 1'b0, 1'b0);
        p = DIRECTED_BASE;
        queue_trb(p[31:0], p[63:32], '1, '1, TRB_CMD_COMPLETION, 1'b0, 1'b0);
        queue_trb($urandom, $urandom, $urandom, $urandom, TRB_TRANSFER, 1'b1, 1'b0);
        wait_idle();

        // random phases across several command ring bases, extremes included
        write_ring_base(64'd0);
        queue_random_trbs(100, -1);
        wait_idle();
        write_ring_base('1);
        queue_random_trbs(100, 50);
        wait_idle();
        write_ring_base(64'hFFFF_FFFF_FFFF_F800);
        queue_random_trbs(100, -1);
        wait_idle();
        write_ring_base({$urandom, $urandom} & ~64'hF);
        queue_random_trbs(100, -1);
        wait_idle();

        $display("Run covered %0d TRBs: %0d taken, %0d on an empty ring, %0d ring wraps,",
                 n_taken + n_empty, n_taken, n_empty, n_wraps);
        $display("%0d command slots in range; taken by kind: transfer %0d, command %0d,",
                 n_cmd_slots, kind_hits[0], kind_hits[1]);
        $display("port %0d, doorbell %0d, notify %0d, other %0d",
                 kind_hits[2], kind_hits[3], kind_hits[4], kind_hits[5]);
        if (mismatches == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #2_000_000;
        $display("Timeout: run did not complete, %0d events pending", pending_events.size());
        $display("Simulation FAILED");
        $finish;
    end

endmodule
